### design/bpbcd_pkg.sv
// ---------------------------------------------------------------------------
// bpbcd_pkg
// Shared types and constants for the binary / packed BCD converter.
// ---------------------------------------------------------------------------
package bpbcd_pkg;

    localparam int unsigned BCD_DIGITS_DEF = 8;
    localparam int unsigned OPERAND_W      = 32;
    localparam int unsigned NIB_W          = 4;
    // Decimal digits a 32-bit binary word can need.
    localparam int unsigned FULL_DIGITS    = 10;
    localparam int unsigned ACC_W          = FULL_DIGITS * NIB_W;
    localparam int unsigned PIPE_STAGES    = OPERAND_W / NIB_W;

    localparam logic [NIB_W-1:0] DIGIT_MAX   = 4'd9;
    localparam logic [NIB_W-1:0] DABBLE_TRIG = 4'd5;
    localparam logic [NIB_W-1:0] DABBLE_ADD  = 4'd3;

    typedef enum logic {
        CMD_TO_BCD   = 1'b0,
        CMD_FROM_BCD = 1'b1
    } cmd_t;

    // Per-stage payload: src shifts out one nibble per stage, acc holds the
    // BCD digits being built (to-BCD) or the binary running sum (from-BCD).
    typedef struct packed {
        cmd_t                 command;
        logic [OPERAND_W-1:0] src;
        logic [ACC_W-1:0]     acc;
    } stage_data_t;

endpackage

### design/bpbcd_stage.sv
// ---------------------------------------------------------------------------
// bpbcd_stage
// One pipeline stage: four double-dabble steps or one decimal Horner step,
// with its own valid bit and ready backpressure.
// ---------------------------------------------------------------------------
module bpbcd_stage #(
    parameter int unsigned STAGE_IDX = 0,
    parameter int unsigned DIGITS    = bpbcd_pkg::BCD_DIGITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bpbcd_pkg::stage_data_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bpbcd_pkg::stage_data_t  out_data
);
    import bpbcd_pkg::*;

    // Stage 0 takes the top nibble, so the digit weight falls stage by stage.
    localparam int unsigned DIGIT_POS  = PIPE_STAGES - 1 - STAGE_IDX;
    localparam bit          DIGIT_USED = (DIGIT_POS < DIGITS);

    logic        valid_reg;
    stage_data_t data_reg;
    stage_data_t data_next;

    logic [ACC_W-1:0]     bcd;
    logic [OPERAND_W-1:0] bits;
    logic [NIB_W-1:0]     digit;
    logic [ACC_W-1:0]     bin;

    always_comb begin
        bcd  = in_data.acc;
        bits = in_data.src;
        for (int s = 0; s < NIB_W; s++) begin
            for (int n = 0; n < FULL_DIGITS; n++) begin
                if (bcd[n*NIB_W +: NIB_W] >= DABBLE_TRIG) begin
                    bcd[n*NIB_W +: NIB_W] = bcd[n*NIB_W +: NIB_W] + DABBLE_ADD;
                end
            end
            bcd  = {bcd[ACC_W-2:0], bits[OPERAND_W-1]};
            bits = {bits[OPERAND_W-2:0], 1'b0};
        end

        // Clamp out-of-range nibbles; drop nibbles beyond the digit count.
        digit = in_data.src[OPERAND_W-1 -: NIB_W];
        if (digit > DIGIT_MAX) begin
            digit = DIGIT_MAX;
        end
        if (!DIGIT_USED) begin
            digit = '0;
        end
        bin = (in_data.acc << 3) + (in_data.acc << 1) + ACC_W'(digit);

        data_next         = in_data;
        data_next.src     = bits;
        data_next.acc     = (in_data.command == CMD_TO_BCD) ? bcd : bin;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### design/binary_packed_bcd_converter.sv
// ---------------------------------------------------------------------------
// binary_packed_bcd_converter
// Binary to packed BCD and packed BCD to binary converter, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one request per cycle unless stalled and returns results in order:
// eight conversion stages each retire one nibble of the operand
// (four double-dabble shifts toward BCD, or one multiply-by-ten-and-add step
// toward binary), and an output register formats the result. Backpressure on
// m_ready stalls the whole pipe without losing or repeating a request; empty
// stages fill while the output waits. With command 0, digits_overflow is set
// when the operand needs more than BCD_DIGITS decimal digits.
module binary_packed_bcd_converter #(
    parameter int unsigned BCD_DIGITS = bpbcd_pkg::BCD_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [bpbcd_pkg::OPERAND_W-1:0]   s_operand_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bpbcd_pkg::OPERAND_W-1:0]   m_converted_value,
    output logic                              m_digits_overflow
);
    import bpbcd_pkg::*;

    logic        pipe_valid [PIPE_STAGES+1];
    logic        pipe_ready [PIPE_STAGES+1];
    stage_data_t pipe_data  [PIPE_STAGES+1];

    assign pipe_valid[0]        = s_valid;
    assign s_ready              = pipe_ready[0];
    assign pipe_data[0].command = cmd_t'(s_command);
    assign pipe_data[0].src     = s_operand_value;
    assign pipe_data[0].acc     = '0;

    for (genvar g = 0; g < PIPE_STAGES; g++) begin : g_stage
        bpbcd_stage #(
            .STAGE_IDX (g),
            .DIGITS    (BCD_DIGITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_data   (pipe_data[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_data  (pipe_data[g+1])
        );
    end

    logic                 m_valid_reg;
    logic [OPERAND_W-1:0] conv_reg;
    logic [OPERAND_W-1:0] conv_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    stage_data_t          last;

    assign last = pipe_data[PIPE_STAGES];
    assign pipe_ready[PIPE_STAGES] = !m_valid_reg || m_ready;

    always_comb begin
        conv_next = '0;
        ovf_next  = 1'b0;
        for (int n = 0; n < PIPE_STAGES; n++) begin
            if (n < BCD_DIGITS) begin
                conv_next[n*NIB_W +: NIB_W] = last.acc[n*NIB_W +: NIB_W];
            end
        end
        // Any nonzero digit above the kept ones means the value did not fit.
        for (int n = 0; n < FULL_DIGITS; n++) begin
            if (n >= BCD_DIGITS) begin
                ovf_next = ovf_next | (|last.acc[n*NIB_W +: NIB_W]);
            end
        end
        if (last.command == CMD_FROM_BCD) begin
            conv_next = last.acc[OPERAND_W-1:0];
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_ready[PIPE_STAGES]) begin
            m_valid_reg <= pipe_valid[PIPE_STAGES];
        end
        if (pipe_ready[PIPE_STAGES] && pipe_valid[PIPE_STAGES]) begin
            conv_reg <= conv_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_converted_value = conv_reg;
    assign m_digits_overflow = ovf_reg;

endmodule

### design/bpbcd_checker.sv
// ---------------------------------------------------------------------------
// bpbcd_checker
// Port-level checks for the binary / packed BCD converter.
// ---------------------------------------------------------------------------
module bpbcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_converted_value,
    input logic        m_digits_overflow
);

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An open output drains every stage, so the input must be ready.
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // Overflow only comes from to-BCD requests, whose digits are all decimal.
    a_ovf_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_digits_overflow) |->
            (m_converted_value[3:0]   <= 4'd9) && (m_converted_value[7:4]   <= 4'd9) &&
            (m_converted_value[11:8]  <= 4'd9) && (m_converted_value[15:12] <= 4'd9) &&
            (m_converted_value[19:16] <= 4'd9) && (m_converted_value[23:20] <= 4'd9) &&
            (m_converted_value[27:24] <= 4'd9) && (m_converted_value[31:28] <= 4'd9))
        else $error("overflow with a non-decimal digit");

    // Hold a stalled result.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            m_valid && $stable(m_converted_value) && $stable(m_digits_overflow))
        else $error("stalled result changed");

endmodule

bind binary_packed_bcd_converter bpbcd_checker u_bpbcd_checker (.*);

### dv/tb_binary_packed_bcd_converter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_binary_packed_bcd_converter
// Self-checking bench for the binary / packed BCD converter.
// ---------------------------------------------------------------------------
// Directed corner values in both directions come first, then a stall-free
// stream, random traffic with gaps and output stalls of mixed length, heavy
// output backpressure and bursts that let the pipe run dry. Every accepted
// request is converted here in the bench and queued. Every result that comes
// back is checked against the oldest queued conversion.
module tb_binary_packed_bcd_converter;
    import bpbcd_pkg::*;

    localparam int unsigned DIGITS       = BCD_DIGITS_DEF;
    localparam int unsigned PIPE_LATENCY = 9;
    localparam int unsigned MAX_REPORTS  = 50;

    typedef struct packed {
        logic [OPERAND_W-1:0] value;
        logic                 overflow;
    } conversion_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_command;
    logic [OPERAND_W-1:0] s_operand_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [OPERAND_W-1:0] m_converted_value;
    logic                 m_digits_overflow;

    conversion_t pending_conversions[$];
    int unsigned error_count = 0;
    int unsigned tx_mode     = 1;   // 0: no gaps, 1: some gaps, 2: many gaps
    int unsigned rx_mode     = 1;   // same scale for output stalls
    int unsigned ready_hold  = 0;

    binary_packed_bcd_converter #(
        .BCD_DIGITS(DIGITS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_operand_value   (s_operand_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_converted_value (m_converted_value),
        .m_digits_overflow (m_digits_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("** binary_packed_bcd_converter: FAILED **");
        $finish;
    end

    function automatic conversion_t expected_conversion(cmd_t cmd,
                                                        logic [OPERAND_W-1:0] operand);
        conversion_t      res;
        longint unsigned  rest;
        longint unsigned  limit;
        longint unsigned  weight;
        longint unsigned  sum;
        logic [NIB_W-1:0] nib;
        res = '0;
        if (cmd == CMD_TO_BCD) begin
            rest  = operand;
            limit = 1;
            for (int i = 0; i < DIGITS; i++) begin
                res.value[i*NIB_W +: NIB_W] = NIB_W'(rest % 10);
                rest  = rest / 10;
                limit = limit * 10;
            end
            res.overflow = (operand >= limit);
        end else begin
            weight = 1;
            sum    = 0;
            for (int i = 0; i < DIGITS; i++) begin
                nib = operand[i*NIB_W +: NIB_W];
                // clamp non-decimal nibbles to nine
                if (nib > DIGIT_MAX) begin
                    nib = DIGIT_MAX;
                end
                sum    = sum + nib * weight;
                weight = weight * 10;
            end
            res.value = sum[OPERAND_W-1:0];
        end
        return res;
    endfunction

    function automatic bit idle_now(int unsigned mode);
        if (mode == 0) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < ((mode == 2) ? 45 : 15);
    endfunction

    // mostly short, a few long
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OPERAND_W-1:0] pick_operand(cmd_t cmd);
        logic [OPERAND_W-1:0] v;
        longint               p;
        int unsigned          r;
        r = $urandom_range(0, 9);
        v = '0;
        if (cmd == CMD_TO_BCD) begin
            if (r < 4) begin
                v = $urandom();
            end else if (r < 7) begin
                // hover around a power of ten
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                p = p + $urandom_range(0, 4) - 2;
                v = (p < 0) ? '0 : OPERAND_W'(p);
            end else if (r < 9) begin
                v = $urandom_range(0, 99999999);
            end else begin
                v = $urandom_range(0, 999);
            end
        end else begin
            if (r < 6) begin
                for (int i = 0; i < 8; i++) begin
                    v[i*NIB_W +: NIB_W] = NIB_W'($urandom_range(0, 9));
                end
            end else if (r < 8) begin
                for (int i = 0; i < 8; i++) begin
                    v[i*NIB_W +: NIB_W] = ($urandom_range(0, 9) < 7) ?
                        NIB_W'($urandom_range(0, 9)) : NIB_W'($urandom_range(10, 15));
                end
            end else begin
                v = $urandom();
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // Returns at the acceptance edge, or after the gap that follows it; valid stays high unless a gap follows.
    task automatic send_request(cmd_t cmd, logic [OPERAND_W-1:0] operand);
        int unsigned gap;
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_operand_value <= operand;
        do @(posedge aclk); while (!s_ready);
        if (idle_now(tx_mode)) begin
            gap = idle_length();
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int unsigned count);
        cmd_t cmd;
        repeat (count) begin
            cmd = cmd_t'($urandom_range(0, 1));
            send_request(cmd, pick_operand(cmd));
        end
    endtask

    // Step past the last acceptance edge so its request is queued before checking.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_conversions.size() != 0) @(posedge aclk);
    endtask

    // Input and output handshakes are sampled at the same edge in one place.
    always @(posedge aclk) begin
        conversion_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_conversions.push_back(
                    expected_conversion(cmd_t'(s_command), s_operand_value));
            end
            if (m_valid && m_ready) begin
                if (pending_conversions.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%08h ovf=%0b",
                                              m_converted_value, m_digits_overflow));
                end else begin
                    want = pending_conversions.pop_front();
                    if (m_converted_value !== want.value) begin
                        report_mismatch($sformatf("converted_value %08h, want %08h",
                                                  m_converted_value, want.value));
                    end
                    if (m_digits_overflow !== want.overflow) begin
                        report_mismatch($sformatf("digits_overflow %0b, want %0b",
                                                  m_digits_overflow, want.overflow));
                    end
                end
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (ready_hold > 0) begin
                m_ready <= 1'b0;
                ready_hold--;
            end else if (idle_now(rx_mode)) begin
                m_ready <= 1'b0;
                ready_hold = idle_length() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_to_bcd();
        send_request(CMD_TO_BCD, 32'd0);
        send_request(CMD_TO_BCD, 32'd1);
        send_request(CMD_TO_BCD, 32'd9);
        send_request(CMD_TO_BCD, 32'd10);
        send_request(CMD_TO_BCD, 32'd12345678);
        send_request(CMD_TO_BCD, 32'd99999999);
        send_request(CMD_TO_BCD, 32'd100000000);
        send_request(CMD_TO_BCD, 32'd999999999);
        send_request(CMD_TO_BCD, 32'd1000000000);
        send_request(CMD_TO_BCD, 32'h8000_0000);
        send_request(CMD_TO_BCD, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed_from_bcd();
        send_request(CMD_FROM_BCD, 32'h0000_0000);
        send_request(CMD_FROM_BCD, 32'h9999_9999);
        send_request(CMD_FROM_BCD, 32'h1234_5678);
        send_request(CMD_FROM_BCD, 32'hFFFF_FFFF);
        send_request(CMD_FROM_BCD, 32'hAAAA_AAAA);
        send_request(CMD_FROM_BCD, 32'h0000_000F);
        send_request(CMD_FROM_BCD, 32'hF000_0000);
        send_request(CMD_FROM_BCD, 32'h0909_0909);
        send_request(CMD_FROM_BCD, 32'h5B3C_7D1E);
    endtask

    task automatic test_streaming();
        tx_mode = 0;
        rx_mode = 0;
        send_random(400);
    endtask

    task automatic test_random_traffic();
        tx_mode = 1;
        rx_mode = 1;
        send_random(900);
    endtask

    task automatic test_output_backpressure();
        tx_mode = 0;
        rx_mode = 2;
        send_random(300);
    endtask

    // let the pipe run dry between bursts
    task automatic test_drain_then_burst();
        tx_mode = 1;
        rx_mode = 1;
        repeat (3) begin
            send_random(100);
            wait_for_drain();
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_command       <= CMD_TO_BCD;
        s_operand_value <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_to_bcd();
        test_directed_from_bcd();
        test_streaming();
        test_random_traffic();
        test_output_backpressure();
        test_drain_then_burst();

        wait_for_drain();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("** binary_packed_bcd_converter: PASSED **");
        end else begin
            $display("** binary_packed_bcd_converter: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
design/bpbcd_pkg.sv
design/bpbcd_stage.sv
design/binary_packed_bcd_converter.sv
design/bpbcd_checker.sv
dv/tb_binary_packed_bcd_converter.sv
